// File: rtl/assert_macros.svh
// Assertion helpers shared by the cipher RTL.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset
`define FSBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside of reset
`define FSBC_NEVER(lbl, cond, msg) \
  `FSBC_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/fsbc_pkg.sv
`default_nettype none
package fsbc_pkg;

  // Block and key geometry
  localparam int HALF_W     = 32;
  localparam int KEY_DEPTH  = 8;
  localparam int KEY_IDX_W  = 3;
  localparam int SBOX_COLS  = 8;
  localparam int NIB_W      = 4;
  localparam int COL_W      = 64;
  localparam int ROT        = 11;
  localparam int CFG_IDX_W  = 3;

  // Round counter covers the largest round count
  localparam int MAX_ROUNDS = 32;
  localparam int RND_W      = 5;
  localparam int FWD_ROUNDS = 24;

  // Operation codes of an input word
  localparam logic OP_LOAD_KEY = 1'b0;
  localparam logic OP_ENCRYPT  = 1'b1;

  typedef logic [HALF_W-1:0] half_t;
  typedef logic [SBOX_COLS-1:0][COL_W-1:0] sbox_set_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_WAIT
  } seq_state_e;

  typedef struct packed {
    logic             busy;
    logic             run;
    logic             last;
    logic             load_out;
    logic [RND_W-1:0] rnd;
  } seq_ctrl_t;

  // Key word for a round: words 0..7 three times, then 7..0
  function automatic logic [KEY_IDX_W-1:0] key_sel(input logic [RND_W-1:0] rnd);
    logic [KEY_IDX_W-1:0] low;
    low = rnd[KEY_IDX_W-1:0];
    if (rnd < RND_W'(FWD_ROUNDS)) begin
      key_sel = low;
    end else begin
      key_sel = ~low;
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/fsbc_round.sv
`default_nettype none
module fsbc_round
  import fsbc_pkg::*;
(
  input  half_t     half_i,
  input  half_t     key_i,
  input  sbox_set_t sbox_i,
  output half_t     f_o
);

  half_t sum;
  half_t sub;

  // Add key, substitute each nibble through its column
  always_comb begin
    sum = half_i + key_i;
    sub = '0;
    for (int j = 0; j < SBOX_COLS; j++) begin
      sub[j*NIB_W +: NIB_W] = sbox_i[j][{sum[j*NIB_W +: NIB_W], 2'b00} +: NIB_W];
    end
  end

  // Rotate left
  assign f_o = (sub << ROT) | (sub >> (HALF_W - ROT));

endmodule
`default_nettype wire

// File: rtl/fsbc_seq.sv
`default_nettype none
`include "assert_macros.svh"
module fsbc_seq
  import fsbc_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      out_free_i,
  output seq_ctrl_t ctrl_o
);

  localparam logic [RND_W-1:0] LastRnd = RND_W'(ROUNDS - 1);

  seq_state_e       state_q, state_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic             last;

  assign last = (rnd_q == LastRnd);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE: begin
        if (start_i) state_d = SEQ_RUN;
      end
      SEQ_RUN: begin
        if (last) state_d = out_free_i ? SEQ_IDLE : SEQ_WAIT;
      end
      SEQ_WAIT: begin
        if (out_free_i) state_d = SEQ_IDLE;
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // Clear the round count on start, advance it while running
  always_comb begin
    rnd_d = rnd_q;
    if (start_i) begin
      rnd_d = '0;
    end else if (state_q == SEQ_RUN && !last) begin
      rnd_d = rnd_q + RND_W'(1);
    end
  end

  // Control outputs
  always_comb begin
    ctrl_o.busy     = (state_q != SEQ_IDLE);
    ctrl_o.run      = (state_q == SEQ_RUN);
    ctrl_o.last     = last;
    ctrl_o.rnd      = rnd_q;
    ctrl_o.load_out = out_free_i &&
                      ((state_q == SEQ_RUN && last) || state_q == SEQ_WAIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  `FSBC_ASSERT(a_start_runs, start_i |=> (state_q == SEQ_RUN && rnd_q == '0), "start did not begin round 0")
  `FSBC_ASSERT(a_rnd_steps, (state_q == SEQ_RUN && !last) |=> (state_q == SEQ_RUN && rnd_q == $past(rnd_q) + RND_W'(1)), "round count skipped")
  `FSBC_NEVER(a_start_busy, start_i && state_q != SEQ_IDLE, "start while busy")

endmodule
`default_nettype wire

// File: rtl/feistel_sbox_block_cipher_unit.sv
// Channel | Valid      | Stall       | Payload
// input   | in_valid_i | in_stall_o  | operation_i key_index_i key_word_i block_left_i block_right_i
// output  | out_valid_o| out_stall_i | result_left_o result_right_o
// config  | cfg_we_i   | -           | cfg_index_i cfg_data_i
//
// A key load is written into the key store and gives no word on the output.
// An encryption runs its rounds one after another in the single round unit; the result
// word is registered from the last round, and no new block is taken until the sequencer is idle.
// in_stall_o stays high from an encrypt accept until the result is registered.
// A stalled output holds the last round until the output register frees.
// Reset clears the sequencer, the key store, the substitution columns and out_valid_o.
`default_nettype none
`include "assert_macros.svh"
module feistel_sbox_block_cipher_unit
  import fsbc_pkg::*;
#(
  parameter int ROUNDS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COL_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [KEY_IDX_W-1:0] key_index_i,
  input  logic [HALF_W-1:0]    key_word_i,
  input  logic [HALF_W-1:0]    block_left_i,
  input  logic [HALF_W-1:0]    block_right_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [HALF_W-1:0]    result_left_o,
  output logic [HALF_W-1:0]    result_right_o
);

  sbox_set_t sbox_q;
  half_t     key_q [KEY_DEPTH];
  half_t     left_q, right_q;
  half_t     res_left_q, res_right_q;
  logic      out_valid_q;

  seq_ctrl_t ctrl;
  logic      in_acc, start, key_load, out_free;
  half_t     round_key, f_val, next_left, next_right;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign start    = in_acc && (operation_i == OP_ENCRYPT);
  assign key_load = in_acc && (operation_i == OP_LOAD_KEY);
  assign out_free = !out_valid_q || !out_stall_i;

  fsbc_seq #(
    .ROUNDS(ROUNDS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .out_free_i(out_free),
    .ctrl_o    (ctrl)
  );

  // Pick the round key and run one round
  assign round_key = key_q[key_sel(ctrl.rnd)];

  fsbc_round u_round (
    .half_i(right_q),
    .key_i (round_key),
    .sbox_i(sbox_q),
    .f_o   (f_val)
  );

  assign next_left  = right_q;
  assign next_right = left_q ^ f_val;

  // Substitution columns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbox_q <= '0;
    end else if (cfg_we_i) begin
      sbox_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Key store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_DEPTH; i++) key_q[i] <= '0;
    end else if (key_load) begin
      key_q[key_index_i] <= key_word_i;
    end
  end

  // Load the block, then advance one round per cycle
  always_ff @(posedge clk_i) begin
    if (start) begin
      left_q  <= block_left_i;
      right_q <= block_right_i;
    end else if (ctrl.run) begin
      left_q  <= next_left;
      right_q <= next_right;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      res_left_q  <= ctrl.run ? next_left  : left_q;
      res_right_q <= ctrl.run ? next_right : right_q;
    end
  end

  assign in_stall_o     = ctrl.busy;
  assign out_valid_o    = out_valid_q;
  assign result_left_o  = res_left_q;
  assign result_right_o = res_right_q;

  `FSBC_ASSERT(a_busy_after_start, start |=> in_stall_o, "not busy after encrypt accept")
  `FSBC_NEVER(a_no_overwrite, ctrl.load_out && out_valid_q && out_stall_i, "result word overwritten")
  `FSBC_ASSERT(a_load_sets_valid, ctrl.load_out |=> out_valid_q, "result not presented")
  `FSBC_NEVER(a_load_at_last, ctrl.load_out && ctrl.run && !ctrl.last, "result before last round")

endmodule
`default_nettype wire

// File: sim/tb_feistel_sbox_block_cipher_unit.sv
`timescale 1ns / 1ps
module tb_feistel_sbox_block_cipher_unit;
  import fsbc_pkg::*;

  localparam int NUM_ROUNDS      = 32;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int LOAD_SETTLE     = 4;

  typedef struct packed {
    half_t left;
    half_t right;
  } block_t;

  typedef enum int {
    COLS_ZERO,
    COLS_ONES,
    COLS_IDENTITY,
    COLS_REVERSE,
    COLS_RANDOM
  } cols_kind_e;

  // Track key store and s-box columns, predict each encrypted block
  class cipher_scoreboard;
    logic [COL_W-1:0] columns [SBOX_COLS];
    half_t            key_words [KEY_DEPTH];
    block_t           expected_blocks [$];
    int               errors;

    function new();
      foreach (columns[j]) columns[j] = '0;
      foreach (key_words[k]) key_words[k] = '0;
      errors = 0;
    endfunction

    function void set_column(int j, logic [COL_W-1:0] value);
      columns[j] = value;
    endfunction

    // Add key, substitute each nibble through its column, rotate left
    function half_t round_mix(half_t half, half_t round_key);
      half_t            sum;
      half_t            sub;
      logic [NIB_W-1:0] nib;
      sum = half + round_key;
      sub = '0;
      for (int j = 0; j < SBOX_COLS; j++) begin
        nib = sum[NIB_W*j +: NIB_W];
        sub[NIB_W*j +: NIB_W] = columns[j][NIB_W*nib +: NIB_W];
      end
      return {sub[HALF_W-ROT-1:0], sub[HALF_W-1:HALF_W-ROT]};
    endfunction

    function block_t encipher(half_t left, half_t right);
      half_t  tmp;
      int     sel;
      block_t res;
      for (int r = 0; r < NUM_ROUNDS; r++) begin
        sel = (r < FWD_ROUNDS) ? (r % KEY_DEPTH) : (KEY_DEPTH - 1 - (r % KEY_DEPTH));
        tmp = left ^ round_mix(right, key_words[sel]);
        left = right;
        right = tmp;
      end
      res.left = left;
      res.right = right;
      return res;
    endfunction

    function void note_input(logic op, logic [KEY_IDX_W-1:0] idx, half_t kw,
                             half_t bl, half_t br);
      if (op == OP_LOAD_KEY) begin
        key_words[idx] = kw;
      end else begin
        expected_blocks.insert(expected_blocks.size(), encipher(bl, br));
      end
    endfunction

    function void check_result(half_t left, half_t right);
      block_t want;
      if (expected_blocks.size() == 0) begin
        $error("unexpected result word: left %h right %h", left, right);
        errors++;
        return;
      end
      want = expected_blocks.pop_front();
      if (want.left !== left) begin
        $error("result_left: expected %h, actual %h", want.left, left);
        errors++;
      end
      if (want.right !== right) begin
        $error("result_right: expected %h, actual %h", want.right, right);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_blocks.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COL_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 operation_i = OP_LOAD_KEY;
  logic [KEY_IDX_W-1:0] key_index_i = '0;
  half_t                key_word_i = '0;
  half_t                block_left_i = '0;
  half_t                block_right_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  half_t                result_left_o;
  half_t                result_right_o;

  cipher_scoreboard sb = new();
  bit               quiet = 1'b0;
  bit               sender_idles = 1'b1;
  cols_kind_e       phase_plan [NUM_PHASES] = '{COLS_RANDOM, COLS_ONES, COLS_ZERO,
                                                COLS_IDENTITY, COLS_RANDOM, COLS_REVERSE,
                                                COLS_RANDOM, COLS_RANDOM};

  feistel_sbox_block_cipher_unit #(
    .ROUNDS(NUM_ROUNDS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .key_index_i   (key_index_i),
    .key_word_i    (key_word_i),
    .block_left_i  (block_left_i),
    .block_right_i (block_right_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_left_o (result_left_o),
    .result_right_o(result_right_o)
  );

  always #6 clk_i = ~clk_i;

  // Check every result word taken at the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(result_left_o, result_right_o);
    end
  end

  // Stall the output in random bursts; hold it open once quiet
  initial begin
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
        out_stall_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        if (!quiet) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 18)) @(posedge clk_i);
        end
      end
    end
  end

  // Hold the word until accepted, then note it
  task automatic send_word(logic op, logic [KEY_IDX_W-1:0] idx, half_t kw,
                           half_t bl, half_t br);
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    key_index_i   <= idx;
    key_word_i    <= kw;
    block_left_i  <= bl;
    block_right_i <= br;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, idx, kw, bl, br);
  endtask

  task automatic pause_sender(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drop valid and wait for every pending block
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  function automatic logic [COL_W-1:0] column_value(cols_kind_e kind);
    case (kind)
      COLS_ZERO:     return '0;
      COLS_ONES:     return '1;
      COLS_IDENTITY: return 64'hFEDC_BA98_7654_3210;
      COLS_REVERSE:  return 64'h0123_4567_89AB_CDEF;
      default:       return {$urandom, $urandom};
    endcase
  endfunction

  // Reload all columns while the block is idle
  task automatic setup_columns(cols_kind_e kind);
    logic [COL_W-1:0] value;
    drain_results();
    repeat (LOAD_SETTLE) @(posedge clk_i);
    for (int j = 0; j < SBOX_COLS; j++) begin
      value = column_value(kind);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(j);
      cfg_data_i  <= value;
      @(posedge clk_i);
      sb.set_column(j, value);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic half_t pick_half();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_word();
    logic op;
    op = ($urandom_range(0, 9) < 3) ? OP_LOAD_KEY : OP_ENCRYPT;
    send_word(op, KEY_IDX_W'($urandom_range(0, KEY_DEPTH - 1)), pick_half(),
              pick_half(), pick_half());
  endtask

  initial begin
    #12_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Encrypt with reset columns and keys never loaded
    send_word(OP_ENCRYPT, 3'd7, '1, '0, '0);
    setup_columns(COLS_RANDOM);
    send_word(OP_ENCRYPT, 3'd5, 32'h1234_5678, '1, '1);

    // Load every key word, block fields carry junk
    send_word(OP_LOAD_KEY, 3'd0, '1, '1, '1);
    for (int k = 1; k < KEY_DEPTH - 1; k++) begin
      send_word(OP_LOAD_KEY, KEY_IDX_W'(k), $urandom, $urandom, $urandom);
    end
    send_word(OP_LOAD_KEY, 3'd7, '0, '1, '0);

    // Block extremes, key fields carry junk; then key reloads between encryptions
    send_word(OP_ENCRYPT, 3'd0, '1, '0, '0);
    send_word(OP_ENCRYPT, 3'd7, '0, '1, '1);
    send_word(OP_ENCRYPT, 3'd2, $urandom, 32'hAAAA_AAAA, 32'h5555_5555);
    send_word(OP_ENCRYPT, 3'd4, $urandom, 32'h5555_5555, 32'hAAAA_AAAA);
    send_word(OP_LOAD_KEY, 3'd3, '0, $urandom, $urandom);
    send_word(OP_ENCRYPT, 3'd3, '1, $urandom, $urandom);
    send_word(OP_LOAD_KEY, 3'd5, '1, '0, '0);
    send_word(OP_LOAD_KEY, 3'd5, 32'h8765_4321, '0, '0);
    send_word(OP_ENCRYPT, 3'd1, $urandom, $urandom, $urandom);
    drain_results();
    send_word(OP_ENCRYPT, 3'd6, $urandom, $urandom, $urandom);

    // Random phases, each under its own column setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      setup_columns(phase_plan[p]);
      if (p == NUM_PHASES - 1) begin
        quiet = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 50 == 0) begin
          sender_idles = ($urandom_range(0, 2) != 0);
        end
        if (!quiet && $urandom_range(0, 99) == 0) begin
          drain_results();
        end else if (!quiet && sender_idles && $urandom_range(0, 2) == 0) begin
          pause_sender($urandom_range(1, 18));
        end
        random_word();
      end
    end

    drain_results();
    repeat (2 * NUM_ROUNDS) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
